### src/mns_pkg.sv
// ----------------------------------------------------------------------------
// mns_pkg
// Shared types and constants of the Markov note sampler: field widths,
// request and register codes, and the command bundle from the controller
// to the datapath.
// ----------------------------------------------------------------------------
package mns_pkg;

  localparam int COUNT_W     = 16;
  localparam int SEED_W      = 3;
  localparam int RANDOM_W    = 16;
  localparam int WEIGHT_W    = 8;
  localparam int INC_W       = 8;
  localparam int NOTE_OUT_W  = 3;
  localparam int TOTAL_OUT_W = 19;
  localparam int HISTORY_LEN = 3;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 4;
  localparam int REG_IDX_W   = 2;

  // Request codes carried by req_type.
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_NEXT  = 1'b1;

  // Register indexes (byte address divided by four).
  localparam logic [REG_IDX_W-1:0] REG_INITIAL_WEIGHT = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MAX_COUNT      = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_INCREMENT      = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [WEIGHT_W-1:0] INITIAL_WEIGHT_RST = 8'd0;
  localparam logic [COUNT_W-1:0]  MAX_COUNT_RST      = 16'hFFFF;
  localparam logic [INC_W-1:0]    INCREMENT_RST      = 8'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_seed;  // start request accepted: load the history
    logic load_rand;  // next request accepted: capture the random word
    logic fill_we;    // write the initial weight at the fill address
    logic rd_en;      // read the count of the current row at the note index
    logic sum_en;     // add the returned count to the row total
    logic mul_en;     // scale the random word by the row total
    logic scan_clr;   // prepare the running sum for the draw
    logic scan_en;    // add the returned count to the running sum and test it
    logic update;     // write back the chosen count, shift history, emit result
  } mns_cmd_t;

endpackage

### src/markov_note_sampler.sv
// ----------------------------------------------------------------------------
// markov_note_sampler
// Order-3 Markov chain note sampler with a weighted roulette-wheel draw over
// a table of transition counts, configured through an APB-style port.
// ----------------------------------------------------------------------------
// A next request shows its result on done_o once the controller has walked the
//   sum, scale, scan and update steps; busy drops with it. The block takes no
//   new request until the draw is done: the two passes over the row share the
//   single read port of the count memory.
// A start request keeps busy high while it writes the initial weight into
//   every count.
// Reset is asynchronous and active low; the receiver cannot stall results.
// ----------------------------------------------------------------------------
module markov_note_sampler import mns_pkg::*; #(
  parameter int NOTE_COUNT = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Request channel.
  input  logic                   start,
  output logic                   busy,
  input  logic                   req_type_i,
  input  logic [SEED_W-1:0]      seed_oldest_i,
  input  logic [SEED_W-1:0]      seed_middle_i,
  input  logic [SEED_W-1:0]      seed_newest_i,
  input  logic [RANDOM_W-1:0]    random_i,
  // Result channel.
  output logic                   done_o,
  output logic [NOTE_OUT_W-1:0]  chosen_note_o,
  output logic [TOTAL_OUT_W-1:0] row_total_o,
  // Configuration port.
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready
);

  localparam int NW = $clog2(NOTE_COUNT);
  localparam int AW = 4 * NW;

  logic [WEIGHT_W-1:0] initial_weight_q;
  logic [COUNT_W-1:0]  max_count_q;
  logic [INC_W-1:0]    increment_q;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                cfg_write;

  mns_cmd_t            cmd;
  logic [NW-1:0]       rd_idx;
  logic [AW-1:0]       fill_addr;

  // The configuration port never waits. A write transaction lands in the
  // register selected by the word address; unknown addresses are dropped.
  assign pready    = 1'b1;
  assign reg_idx   = paddr[APB_ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      initial_weight_q <= INITIAL_WEIGHT_RST;
      max_count_q      <= MAX_COUNT_RST;
      increment_q      <= INCREMENT_RST;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_INITIAL_WEIGHT: initial_weight_q <= pwdata[WEIGHT_W-1:0];
        REG_MAX_COUNT:      max_count_q      <= pwdata[COUNT_W-1:0];
        REG_INCREMENT:      increment_q      <= pwdata[INC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_INITIAL_WEIGHT: prdata = APB_DATA_W'(initial_weight_q);
      REG_MAX_COUNT:      prdata = APB_DATA_W'(max_count_q);
      REG_INCREMENT:      prdata = APB_DATA_W'(increment_q);
      default:            prdata = '0;
    endcase
  end

  // The controller walks the fill and the steps of a draw; the datapath holds
  // the count memory, the history and the arithmetic of the draw.
  mns_ctrl #(
    .NOTE_COUNT (NOTE_COUNT)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .req_type_i  (req_type_i),
    .busy_o      (busy),
    .cmd_o       (cmd),
    .rd_idx_o    (rd_idx),
    .fill_addr_o (fill_addr)
  );

  mns_datapath #(
    .NOTE_COUNT (NOTE_COUNT)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .rd_idx_i         (rd_idx),
    .fill_addr_i      (fill_addr),
    .seed_oldest_i    (seed_oldest_i),
    .seed_middle_i    (seed_middle_i),
    .seed_newest_i    (seed_newest_i),
    .random_i         (random_i),
    .initial_weight_i (initial_weight_q),
    .max_count_i      (max_count_q),
    .increment_i      (increment_q),
    .done_o           (done_o),
    .chosen_note_o    (chosen_note_o),
    .row_total_o      (row_total_o)
  );

endmodule

### src/mns_ctrl.sv
// ----------------------------------------------------------------------------
// mns_ctrl
// Sequencer of the sampler: the table fill after a start request, and the
// sum, scale, scan and update steps of a next request.
// ----------------------------------------------------------------------------
module mns_ctrl import mns_pkg::*; #(
  parameter int NOTE_COUNT = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          req_type_i,
  output logic                          busy_o,
  output mns_cmd_t                      cmd_o,
  output logic [$clog2(NOTE_COUNT)-1:0] rd_idx_o,
  output logic [4*$clog2(NOTE_COUNT)-1:0] fill_addr_o
);

  localparam int NW = $clog2(NOTE_COUNT);
  localparam int AW = 4 * NW;
  localparam int CW = NW + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_SUM,
    S_MUL,
    S_SCAN,
    S_UPD
  } state_e;

  state_e          state_q;
  logic [AW-1:0]   fill_cnt_q;
  logic [CW-1:0]   note_cnt_q;
  logic            accept;
  logic            note_last;
  logic            note_rd;

  assign accept    = start_i && (state_q == S_IDLE);
  assign note_last = (note_cnt_q == CW'(NOTE_COUNT));
  assign note_rd   = (note_cnt_q < CW'(NOTE_COUNT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      fill_cnt_q <= '0;
      note_cnt_q <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          fill_cnt_q <= '0;
          note_cnt_q <= '0;
          if (accept) begin
            state_q <= (req_type_i == REQ_START) ? S_FILL : S_SUM;
          end
        end
        S_FILL: begin
          fill_cnt_q <= fill_cnt_q + AW'(1);
          if (fill_cnt_q == {AW{1'b1}}) begin
            state_q <= S_IDLE;
          end
        end
        S_SUM: begin
          if (note_last) begin
            note_cnt_q <= '0;
            state_q    <= S_MUL;
          end else begin
            note_cnt_q <= note_cnt_q + CW'(1);
          end
        end
        S_MUL: begin
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          if (note_last) begin
            note_cnt_q <= '0;
            state_q    <= S_UPD;
          end else begin
            note_cnt_q <= note_cnt_q + CW'(1);
          end
        end
        S_UPD: begin
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.load_seed = accept && (req_type_i == REQ_START);
    cmd_o.load_rand = accept && (req_type_i == REQ_NEXT);
    cmd_o.fill_we   = (state_q == S_FILL);
    cmd_o.rd_en     = ((state_q == S_SUM) || (state_q == S_SCAN)) && note_rd;
    cmd_o.sum_en    = (state_q == S_SUM) && (note_cnt_q != '0);
    cmd_o.mul_en    = (state_q == S_MUL);
    cmd_o.scan_clr  = (state_q == S_MUL);
    cmd_o.scan_en   = (state_q == S_SCAN) && (note_cnt_q != '0);
    cmd_o.update    = (state_q == S_UPD);
  end

  assign busy_o      = (state_q != S_IDLE);
  assign rd_idx_o    = note_cnt_q[NW-1:0];
  assign fill_addr_o = fill_cnt_q;

endmodule

### src/mns_datapath.sv
// ----------------------------------------------------------------------------
// mns_datapath
// Count memory, history, row total, dice scaling, running-sum scan and the
// saturating count update of the sampler.
// ----------------------------------------------------------------------------
module mns_datapath import mns_pkg::*; #(
  parameter int NOTE_COUNT = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  mns_cmd_t                        cmd_i,
  input  logic [$clog2(NOTE_COUNT)-1:0]   rd_idx_i,
  input  logic [4*$clog2(NOTE_COUNT)-1:0] fill_addr_i,
  input  logic [SEED_W-1:0]               seed_oldest_i,
  input  logic [SEED_W-1:0]               seed_middle_i,
  input  logic [SEED_W-1:0]               seed_newest_i,
  input  logic [RANDOM_W-1:0]             random_i,
  input  logic [WEIGHT_W-1:0]             initial_weight_i,
  input  logic [COUNT_W-1:0]              max_count_i,
  input  logic [INC_W-1:0]                increment_i,
  output logic                            done_o,
  output logic [NOTE_OUT_W-1:0]           chosen_note_o,
  output logic [TOTAL_OUT_W-1:0]          row_total_o
);

  localparam int NW      = $clog2(NOTE_COUNT);
  localparam int AW      = 4 * NW;
  localparam int DEPTH   = 1 << AW;
  localparam int TOTAL_W = COUNT_W + NW;
  localparam int PROD_W  = RANDOM_W + TOTAL_W + 1;

  // A seed at or above the note count wraps around; seeds are narrow, so a
  // few conditional subtractions cover every value.
  function automatic logic [NW-1:0] fold_note(input logic [SEED_W-1:0] seed);
    logic [4:0] v;
    v = 5'(seed);
    for (int k = 0; k < 4; k++) begin
      if (v >= 5'(NOTE_COUNT)) begin
        v = v - 5'(NOTE_COUNT);
      end
    end
    return NW'(v);
  endfunction

  logic [COUNT_W-1:0]  mem_q [DEPTH];
  logic [NW-1:0]       hist_q [HISTORY_LEN];
  logic [COUNT_W-1:0]  rd_data_q;
  logic [NW-1:0]       rd_idx_q;
  logic [RANDOM_W-1:0] random_q;
  logic [TOTAL_W-1:0]  total_q;
  logic [PROD_W-1:0]   prod_q;
  logic [TOTAL_W-1:0]  run_q;
  logic                found_q;
  logic [NW-1:0]       pick_q;
  logic [COUNT_W-1:0]  pick_cnt_q;
  logic                done_q;
  logic [NOTE_OUT_W-1:0]  chosen_note_q;
  logic [TOTAL_OUT_W-1:0] row_total_q;

  logic [AW-1:0]       rd_addr;
  logic [AW-1:0]       upd_addr;
  logic [TOTAL_W:0]    total_p1;
  logic [TOTAL_W-1:0]  dice;
  logic [TOTAL_W-1:0]  run_next;
  logic                hit;
  logic [COUNT_W:0]    cnt_sum;
  logic [COUNT_W-1:0]  cnt_new;
  logic                cnt_grow;

  assign rd_addr  = {hist_q[0], hist_q[1], hist_q[2], rd_idx_i};
  assign upd_addr = {hist_q[0], hist_q[1], hist_q[2], pick_q};
  assign total_p1 = {1'b0, total_q} + (TOTAL_W + 1)'(1);
  assign dice     = prod_q[RANDOM_W +: TOTAL_W];
  assign run_next = run_q + TOTAL_W'(rd_data_q);
  assign hit      = (dice <= run_next);
  assign cnt_sum  = {1'b0, pick_cnt_q} + (COUNT_W + 1)'(increment_i);
  assign cnt_new  = cnt_sum[COUNT_W] ? {COUNT_W{1'b1}} : cnt_sum[COUNT_W-1:0];
  assign cnt_grow = (pick_cnt_q < max_count_i);

  // Count memory: one write port shared by the fill and the update, one
  // registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.fill_we) begin
      mem_q[fill_addr_i] <= COUNT_W'(initial_weight_i);
    end else if (cmd_i.update && cnt_grow) begin
      mem_q[upd_addr] <= cnt_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr];
      rd_idx_q  <= rd_idx_i;
    end
  end

  // Payload registers of the draw.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_rand) begin
      random_q <= random_i;
      total_q  <= '0;
    end else if (cmd_i.sum_en) begin
      total_q <= total_q + TOTAL_W'(rd_data_q);
    end
    if (cmd_i.mul_en) begin
      prod_q <= PROD_W'(random_q) * PROD_W'(total_p1);
    end
    if (cmd_i.scan_clr) begin
      run_q      <= '0;
      pick_q     <= NW'(NOTE_COUNT - 1);
      pick_cnt_q <= '0;
    end else if (cmd_i.scan_en && !found_q) begin
      run_q <= run_next;
      if (hit || (rd_idx_q == NW'(NOTE_COUNT - 1))) begin
        pick_q     <= rd_idx_q;
        pick_cnt_q <= rd_data_q;
      end
    end
    if (cmd_i.update) begin
      chosen_note_q <= NOTE_OUT_W'(pick_q);
      row_total_q   <= TOTAL_OUT_W'(total_q);
    end
  end

  // History and result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < HISTORY_LEN; k++) begin
        hist_q[k] <= '0;
      end
      found_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= cmd_i.update;
      if (cmd_i.load_seed) begin
        hist_q[0] <= fold_note(seed_oldest_i);
        hist_q[1] <= fold_note(seed_middle_i);
        hist_q[2] <= fold_note(seed_newest_i);
      end else if (cmd_i.update) begin
        for (int k = 0; k < HISTORY_LEN - 1; k++) begin
          hist_q[k] <= hist_q[k+1];
        end
        hist_q[HISTORY_LEN-1] <= pick_q;
      end
      if (cmd_i.scan_clr) begin
        found_q <= 1'b0;
      end else if (cmd_i.scan_en && hit) begin
        found_q <= 1'b1;
      end
    end
  end

  assign done_o        = done_q;
  assign chosen_note_o = chosen_note_q;
  assign row_total_o   = row_total_q;

endmodule

### src/mns_checker.sv
// ----------------------------------------------------------------------------
// mns_checker
// Port-level assertions of the Markov note sampler, bound to the top level.
// ----------------------------------------------------------------------------
module mns_checker import mns_pkg::*; #(
  parameter int NOTE_COUNT = 8
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  start,
  input logic                  busy,
  input logic                  done_o,
  input logic [NOTE_OUT_W-1:0] chosen_note_o
);

  // An accepted transaction always makes the block busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
  else $error("accepted transaction did not raise busy");

  // A result only follows a busy period and arrives when the block is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (!busy && $past(busy)))
  else $error("result strobe outside the end of a draw");

  // Every draw walks its row twice, so two results never touch.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
  else $error("result strobe longer than one cycle");

  // The chosen note lies within the note range where the port can show it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((NOTE_COUNT >= 8) || (32'(chosen_note_o) < NOTE_COUNT)))
  else $error("chosen note out of range");

endmodule

bind markov_note_sampler mns_checker #(
  .NOTE_COUNT (NOTE_COUNT)
) u_mns_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .chosen_note_o (chosen_note_o)
);

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Markov note sampler. A queue-fed driver issues
// start and next transactions with random gaps. A bit-exact software copy of
// the count table and the note history predicts every draw. A monitor checks
// each result strobe against the oldest prediction. Register settings change
// between phases, and each change waits until the sampler is idle.
// ----------------------------------------------------------------------------
module tb_top import mns_pkg::*; ();

  localparam int NOTES         = 8;
  localparam int TABLE_DEPTH   = NOTES * NOTES * NOTES * NOTES;
  // A start keeps the sampler busy for a full table fill, and a draw returns its
  // result after the sum, scale, scan and update steps.
  localparam int FILL_CYCLES   = TABLE_DEPTH;
  localparam int DRAW_LATENCY  = 2 * NOTES + 4;
  localparam int SETTLE_CYCLES = FILL_CYCLES + DRAW_LATENCY + 8;
  // The longest quiet stretch of a correct run is one fill plus a settle
  // pause, and the watchdog limit lies above it.
  localparam int WATCHDOG_LIMIT = 4 * SETTLE_CYCLES;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_ITEMS    = 70;
  localparam int SAT_DRAWS      = 270;

  // One request transaction as the driver presents it.
  typedef struct {
    logic                kind;
    logic [SEED_W-1:0]   seed_old;
    logic [SEED_W-1:0]   seed_mid;
    logic [SEED_W-1:0]   seed_new;
    logic [RANDOM_W-1:0] rnd;
    bit                  drain;  // hold off until every draw has returned
  } request_t;

  // The draw that a next transaction must produce.
  typedef struct {
    logic [NOTE_OUT_W-1:0]  note;
    logic [TOTAL_OUT_W-1:0] total;
  } draw_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                   start = 1'b0;
  logic                   req_type_i = REQ_START;
  logic [SEED_W-1:0]      seed_oldest_i = '0;
  logic [SEED_W-1:0]      seed_middle_i = '0;
  logic [SEED_W-1:0]      seed_newest_i = '0;
  logic [RANDOM_W-1:0]    random_i = '0;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]  paddr = '0;
  logic [APB_DATA_W-1:0]  pwdata = '0;

  logic                   busy;
  logic                   done_o;
  logic [NOTE_OUT_W-1:0]  chosen_note_o;
  logic [TOTAL_OUT_W-1:0] row_total_o;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  // Software copy of the sampler state and its registers.
  logic [COUNT_W-1:0]  count_table [TABLE_DEPTH];
  logic [SEED_W-1:0]   note_history [HISTORY_LEN] = '{default: '0};
  logic [WEIGHT_W-1:0] weight_setting = INITIAL_WEIGHT_RST;
  logic [COUNT_W-1:0]  max_setting    = MAX_COUNT_RST;
  logic [INC_W-1:0]    inc_setting    = INCREMENT_RST;

  request_t request_q[$];
  draw_t    expected_draws[$];
  request_t cur_req;
  int       gap_left = 0;
  bit       gaps_enabled = 1'b1;
  int       failures = 0;
  int       idle_cycles = 0;

  markov_note_sampler #(
    .NOTE_COUNT(NOTES)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_type_i    (req_type_i),
    .seed_oldest_i (seed_oldest_i),
    .seed_middle_i (seed_middle_i),
    .seed_newest_i (seed_newest_i),
    .random_i      (random_i),
    .done_o        (done_o),
    .chosen_note_o (chosen_note_o),
    .row_total_o   (row_total_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #2 clk_i = ~clk_i;

  // Advances the software copy by one accepted transaction. A start fills the
  // table and loads the history; a next performs the weighted draw and queues
  // the result it must produce.
  task automatic predict_draw(input request_t r);
    int unsigned      base;
    int unsigned      total;
    int unsigned      dice;
    int unsigned      run;
    int unsigned      pick;
    int unsigned      cnt;
    longint unsigned  product;
    int               i;
    draw_t            d;
    if (r.kind == REQ_START) begin
      for (i = 0; i < TABLE_DEPTH; i++) begin
        count_table[i] = COUNT_W'(weight_setting);
      end
      note_history[0] = r.seed_old;
      note_history[1] = r.seed_mid;
      note_history[2] = r.seed_new;
    end else begin
      base = ((note_history[0] * NOTES + note_history[1]) * NOTES + note_history[2]) * NOTES;
      total = 0;
      for (i = 0; i < NOTES; i++) begin
        total += count_table[base + i];
      end
      // The dice is the random word scaled onto 0..total.
      product = longint'(r.rnd) * (longint'(total) + 1);
      dice = int'(product >> 16);
      // Walk the row again and take the first note whose running sum
      // reaches the dice. The last note is the fallback, never expected.
      pick = NOTES - 1;
      run = 0;
      for (i = 0; i < NOTES; i++) begin
        run += count_table[base + i];
        if (dice <= run) begin
          pick = i;
          break;
        end
      end
      // The chosen count grows only while below the limit, and the sum
      // saturates at the full count width.
      cnt = count_table[base + pick];
      if (cnt < max_setting) begin
        cnt += inc_setting;
        if (cnt > 65535) begin
          cnt = 65535;
        end
        count_table[base + pick] = COUNT_W'(cnt);
      end
      note_history[0] = note_history[1];
      note_history[1] = note_history[2];
      note_history[2] = SEED_W'(pick);
      d.note  = NOTE_OUT_W'(pick);
      d.total = TOTAL_OUT_W'(total);
      expected_draws.push_back(d);
    end
  endtask

  // Gap before the next transaction: mostly none or short, now and then long.
  function automatic int next_gap();
    int r;
    if (!gaps_enabled) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 20);
    end
    return $urandom_range(21, 60);
  endfunction

  // Random word for a draw, weighted toward the small and large ends.
  function automatic logic [RANDOM_W-1:0] draw_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      return RANDOM_W'($urandom_range(0, 65535));
    end else if (r < 80) begin
      return RANDOM_W'($urandom_range(0, 255));
    end else if (r < 90) begin
      return RANDOM_W'(65535 - $urandom_range(0, 255));
    end
    return ($urandom_range(0, 1) == 1) ? '1 : '0;
  endfunction

  // The seed fields of a next and the random field of a start are don't-care
  // inputs, so they carry noise.
  function automatic void queue_start(input int s_old, input int s_mid, input int s_new,
                                      input bit drain = 1'b0);
    request_t r;
    r.kind     = REQ_START;
    r.seed_old = SEED_W'(s_old);
    r.seed_mid = SEED_W'(s_mid);
    r.seed_new = SEED_W'(s_new);
    r.rnd      = RANDOM_W'($urandom);
    r.drain    = drain;
    request_q.push_back(r);
  endfunction

  function automatic void queue_next(input logic [RANDOM_W-1:0] rnd,
                                     input bit drain = 1'b0);
    request_t r;
    r.kind     = REQ_NEXT;
    r.seed_old = SEED_W'($urandom);
    r.seed_mid = SEED_W'($urandom);
    r.seed_new = SEED_W'($urandom);
    r.rnd      = rnd;
    r.drain    = drain;
    request_q.push_back(r);
  endfunction

  // Register write: a setup cycle, then an access cycle that completes at the
  // edge where pready is seen high.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int unsigned value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'({idx, 2'b00});
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_INITIAL_WEIGHT: weight_setting = WEIGHT_W'(value);
      REG_MAX_COUNT:      max_setting    = COUNT_W'(value);
      REG_INCREMENT:      inc_setting    = INC_W'(value);
      default: ;
    endcase
  endtask

  task automatic set_config(input int unsigned weight, input int unsigned max_cnt,
                            input int unsigned inc);
    write_reg(REG_INITIAL_WEIGHT, weight);
    write_reg(REG_MAX_COUNT, max_cnt);
    write_reg(REG_INCREMENT, inc);
  endtask

  // Waits until every queued transaction is taken and every draw has come
  // back, then lets a possible table fill run out before anything else.
  task automatic wait_idle();
    while (request_q.size() != 0 || start || expected_draws.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Driver. The sampler takes a transaction at an edge where start is high and
  // busy is low. A transaction that follows with no gap keeps start high, so
  // start never gets two assignments in one step.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        predict_draw(cur_req);
        gap_left = next_gap();
      end
      if ((start && !busy) || !start) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (request_q.size() != 0 &&
                     !(request_q[0].drain && expected_draws.size() != 0)) begin
          cur_req = request_q.pop_front();
          req_type_i    <= cur_req.kind;
          seed_oldest_i <= cur_req.seed_old;
          seed_middle_i <= cur_req.seed_mid;
          seed_newest_i <= cur_req.seed_new;
          random_i      <= cur_req.rnd;
          start         <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor and watchdog. Every strobe is a result that cannot be held off,
  // so each one is checked against the oldest prediction on the edge that
  // closes its cycle. Any accepted transaction on either port counts as
  // progress for the watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        if (expected_draws.size() == 0) begin
          $display("%0t ns: result with no draw pending, expected none, actual note %0d total %0d",
                   $time, chosen_note_o, row_total_o);
          failures++;
        end else begin
          if (chosen_note_o !== expected_draws[0].note) begin
            $display("%0t ns: chosen_note mismatch, expected %0d, actual %0d",
                     $time, expected_draws[0].note, chosen_note_o);
            failures++;
          end
          if (row_total_o !== expected_draws[0].total) begin
            $display("%0t ns: row_total mismatch, expected %0d, actual %0d",
                     $time, expected_draws[0].total, row_total_o);
            failures++;
          end
          void'(expected_draws.pop_front());
        end
      end
      if (done_o || (start && !busy) || (psel && penable && pready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("markov_note_sampler verification failed");
        $finish;
      end
    end
  end

  initial begin
    int p;
    int n;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset register values: zero weight, so every row starts empty, each draw
    // picks note 0 and its count grows by one. Seeds cover the all-zero and
    // all-one histories and a mixed one.
    queue_start(0, 0, 0);
    queue_next('0);
    queue_next('1);
    queue_next(16'h8000);
    queue_next(16'h0001);
    queue_start(7, 7, 7);
    queue_next('1);
    queue_next(16'hFFFE);
    queue_start(5, 2, 6);
    queue_next(16'h5555);
    queue_next(16'hAAAA);
    wait_idle();

    // Largest weight and increment with a zero limit: counts never grow.
    set_config(255, 0, 255);
    queue_start(3, 6, 1);
    queue_next('0);
    queue_next('1);
    queue_next(16'h1234);
    wait_idle();

    // Zero increment: a count below the limit is written back unchanged.
    set_config(1, 3, 0);
    queue_start(2, 4, 7);
    queue_next('1);
    queue_next('0);
    queue_next(16'h7FFF);
    wait_idle();

    // Random phases under varied settings. Most transactions are draws; a
    // few starts reseed the table, and a few hold off until all draws have
    // come back. Every third phase runs with no gaps at all.
    for (p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 3))
        0:       weight_setting = '0;
        1:       weight_setting = '1;
        default: weight_setting = WEIGHT_W'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 4))
        0:       max_setting = '0;
        1:       max_setting = '1;
        2:       max_setting = COUNT_W'($urandom_range(1, 600));
        default: max_setting = COUNT_W'($urandom_range(0, 65535));
      endcase
      case ($urandom_range(0, 5))
        0:       inc_setting = INC_W'(1);
        1:       inc_setting = '1;
        2:       inc_setting = '0;
        default: inc_setting = INC_W'($urandom_range(1, 255));
      endcase
      set_config(weight_setting, max_setting, inc_setting);
      gaps_enabled = (p % 3 != 1);
      if (p == 0 || $urandom_range(0, 1) == 1) begin
        queue_start($urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 7));
      end
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 24) == 0) begin
          queue_start($urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 7),
                      $urandom_range(0, 29) == 0);
        end else begin
          queue_next(draw_word(), $urandom_range(0, 29) == 0);
        end
      end
      wait_idle();
    end

    // Saturation run: small random words keep picking note 0 from the
    // all-zero history, so one count climbs by the largest increment until it
    // clamps at the full count width and then stays there.
    gaps_enabled = 1'b1;
    set_config(200, 65535, 255);
    queue_start(0, 0, 0);
    for (n = 0; n < SAT_DRAWS; n++) begin
      queue_next(RANDOM_W'($urandom_range(0, 255)));
    end
    wait_idle();

    if (expected_draws.size() != 0) begin
      $display("%0t ns: draws left over, expected 0, actual %0d",
               $time, expected_draws.size());
      failures++;
    end
    if (failures == 0) begin
      $display("markov_note_sampler verification clean");
    end else begin
      $display("markov_note_sampler verification failed");
    end
    $finish;
  end

endmodule
